// ----- sv/range_record_slot_assigner_core_defines.svh -----
// Assertion macros for the range record slot assigner.
// Used by files that assert; no dependencies.
`ifndef RANGE_RECORD_SLOT_ASSIGNER_CORE_DEFINES_SVH
`define RANGE_RECORD_SLOT_ASSIGNER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of i_clk, ignored while i_rst_n is low.
`define RRSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every rising edge of i_clk, reset included.
`define RRSA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RRSA_ASSERT(lbl, prop, msg)
`define RRSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- sv/rrsa_pkg.sv -----
// Shared types, constants and decode function of the range record slot assigner.
// No dependencies.
package rrsa_pkg;

    localparam int unsigned SLOT_W    = 6;
    localparam int unsigned OBS_W     = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_W     = 8;
    localparam int unsigned SAT_W     = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BDS = 2'd1;

    localparam logic [CFG_W-1:0] MAX_GPS_RESET = 8'd32;
    localparam logic [CFG_W-1:0] MAX_BDS_RESET = 8'd63;

    // Tracking word fields.
    localparam int unsigned SYS_LSB    = 16;
    localparam int unsigned SIG_LSB    = 21;
    localparam int unsigned PHASE_BIT  = 10;
    localparam int unsigned PARITY_BIT = 11;
    localparam int unsigned CODE_BIT   = 12;
    localparam int unsigned HALF_BIT   = 28;

    localparam logic [2:0] SYS_GPS = 3'd0;
    localparam logic [2:0] SYS_BDS = 3'd4;

    localparam logic [4:0] SIG_GPS_F1  = 5'd0;
    localparam logic [4:0] SIG_GPS_F2  = 5'd9;
    localparam logic [4:0] SIG_BDS_F1A = 5'd0;
    localparam logic [4:0] SIG_BDS_F1B = 5'd4;
    localparam logic [4:0] SIG_BDS_F2A = 5'd2;
    localparam logic [4:0] SIG_BDS_F2B = 5'd6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESOLVE
    } t_state;

    // Satellite number and system of one slot, also the search key.
    typedef struct packed {
        logic [SAT_W-1:0] sat;
        logic             bds;
    } t_entry;

    // Search probe handed from cell to cell.
    typedef struct packed {
        logic tok;
        logic found;
    } t_probe;

    typedef struct packed {
        logic known;
        logic band;
    } t_band_dec;

    function automatic t_band_dec f_band_decode(input logic bds, input logic [4:0] sig);
        t_band_dec d;
        d = '{known: 1'b0, band: 1'b0};
        if (!bds) begin
            if (sig == SIG_GPS_F1) begin
                d = '{known: 1'b1, band: 1'b0};
            end else if (sig == SIG_GPS_F2) begin
                d = '{known: 1'b1, band: 1'b1};
            end
        end else begin
            if (sig == SIG_BDS_F1A || sig == SIG_BDS_F1B) begin
                d = '{known: 1'b1, band: 1'b0};
            end else if (sig == SIG_BDS_F2A || sig == SIG_BDS_F2B) begin
                d = '{known: 1'b1, band: 1'b1};
            end
        end
        return d;
    endfunction

endpackage

// ----- sv/range_record_slot_assigner_core.sv -----
// Range record slot assigner: top level with the record decoder, sequencer and slot chain.
// Depends on rrsa_pkg, rrsa_chain and the assertion macro header.
//
// Usage: one receiver range record is taken per input beat (i_in_valid high,
// o_in_stall low) and one result beat is given for each record on the output
// channel (o_out_valid high, i_out_stall low). Records are handled one at a
// time. A record that needs no table search (first band, or rejected by
// decode) goes straight to the resolve step. A second-band record sends a
// probe down the row of SLOTS slot cells, one cell per cycle, and is
// resolved once the probe leaves the last cell; no new record is taken
// during that walk, so the walk limits the record rate.
// The next record is accepted as soon as the previous one has been placed in
// the output register, so a stalled result does not block decoding or the
// table search of the following record; only the final table write waits
// for the output register to free up.
// Reset clears all slot used flags, the observation count and the output valid, and
// loads the satellite limits with 32 (GPS) and 63 (BDS). The limits are to be written
// through the configuration port while the block idles; the block does not enforce it.
`include "range_record_slot_assigner_core_defines.svh"

module range_record_slot_assigner_core import rrsa_pkg::*; #(
    parameter int unsigned SLOTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_epoch_start,
    input  logic [31:0]          i_track_status,
    input  logic [SAT_W-1:0]     i_sat_number,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_accepted,
    output logic [SLOT_W-1:0]    o_slot,
    output logic                 o_band,
    output logic                 o_system_code,
    output logic                 o_code_valid,
    output logic                 o_phase_valid,
    output logic                 o_parity_known,
    output logic                 o_half_cycle,
    output logic [OBS_W-1:0]     o_obs_count
);

    localparam int unsigned IDX_W = $clog2(SLOTS);
    localparam int unsigned CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_max_gps, r_max_bds;

    // Decoded record.
    logic             r_known, r_band, r_bds;
    logic             r_code, r_phase, r_parity, r_half;
    logic [SAT_W-1:0] r_sat;
    logic             r_start;
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [CNT_W-1:0] r_count, n_count;

    logic              r_out_valid;
    logic              r_acc, r_o_band, r_o_bds, r_o_code, r_o_phase, r_o_parity, r_o_half;
    logic [SLOT_W-1:0] r_o_slot;
    logic [OBS_W-1:0]  r_o_obs;

    logic [2:0]   in_sys;
    logic         in_gps, in_bds;
    t_band_dec    in_dec;
    logic         in_known;
    logic         in_accept;
    logic         start_search;
    logic         resolve_go;
    logic         out_free;
    t_probe       tail;
    logic [IDX_W-1:0] tail_idx;
    logic [CNT_W-1:0] m_slot;
    logic         in_table;
    logic         wr_en;
    logic [CFG_W-1:0] limit;
    logic         in_range;
    logic         ok;
    t_entry       query;

    // Input decode.
    assign in_sys   = i_track_status[SYS_LSB +: 3];
    assign in_gps   = (in_sys == SYS_GPS);
    assign in_bds   = (in_sys == SYS_BDS);
    assign in_dec   = f_band_decode(in_bds, i_track_status[SIG_LSB +: 5]);
    assign in_known = (in_gps || in_bds) && in_dec.known;
    assign out_free = !r_out_valid || !i_out_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (in_known && in_dec.band) ? S_SEARCH : S_RESOLVE;
                end
            end
            S_SEARCH: begin
                if (tail.tok) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall   = 1'b1;
        in_accept    = 1'b0;
        start_search = 1'b0;
        resolve_go   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                in_accept    = i_in_valid;
                start_search = i_in_valid && in_known && in_dec.band;
            end
            S_SEARCH: begin
            end
            S_RESOLVE: begin
                resolve_go = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_gps <= MAX_GPS_RESET;
            r_max_bds <= MAX_BDS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_MAX_GPS) begin
                r_max_gps <= i_cfg_data;
            end
            if (i_cfg_index == REG_MAX_BDS) begin
                r_max_bds <= i_cfg_data;
            end
        end
    end

    // Record capture.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_known  <= in_known;
            r_band   <= in_dec.band;
            r_bds    <= in_bds;
            r_sat    <= i_sat_number;
            r_code   <= i_track_status[CODE_BIT];
            r_phase  <= i_track_status[PHASE_BIT];
            r_parity <= i_track_status[PARITY_BIT];
            r_half   <= i_track_status[HALF_BIT];
        end
    end

    // The probe leaves in the cycle after accept, once the search key is registered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= start_search;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (in_accept) begin
            r_hit <= 1'b0;
        end else if (r_state == S_SEARCH && tail.tok) begin
            r_hit <= tail.found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SEARCH && tail.tok) begin
            r_hit_idx <= tail_idx;
        end
    end

    assign query = '{sat: r_sat, bds: r_bds};

    rrsa_chain #(
        .SLOTS(SLOTS),
        .IDX_W(IDX_W)
    ) u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_query   (query),
        .i_wr_en   (wr_en),
        .i_wr_addr (m_slot[IDX_W-1:0]),
        .i_start   (r_start),
        .o_tail    (tail),
        .o_tail_idx(tail_idx)
    );

    // Slot choice, table write and range check.
    assign m_slot   = (r_band && r_hit) ? CNT_W'(r_hit_idx) : r_count;
    assign in_table = (m_slot < SLOTS_C);
    assign wr_en    = resolve_go && r_known && in_table;
    assign limit    = r_bds ? r_max_bds : r_max_gps;
    assign in_range = (r_sat <= SAT_W'(limit));
    assign ok       = r_known && in_table && in_range;

    always_comb begin
        n_count = r_count;
        if (ok && !r_band && r_count < SLOTS_C) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (in_accept && i_epoch_start) begin
            r_count <= '0;
        end else if (resolve_go) begin
            r_count <= n_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (resolve_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (resolve_go) begin
            r_acc      <= ok;
            r_o_slot   <= ok ? SLOT_W'(m_slot) : '0;
            r_o_band   <= ok && r_band;
            r_o_bds    <= ok && r_bds;
            r_o_code   <= ok && r_code;
            r_o_phase  <= ok && r_phase;
            r_o_parity <= ok && r_parity;
            r_o_half   <= ok && r_half;
            r_o_obs    <= OBS_W'(n_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_acc;
    assign o_slot         = r_o_slot;
    assign o_band         = r_o_band;
    assign o_system_code  = r_o_bds;
    assign o_code_valid   = r_o_code;
    assign o_phase_valid  = r_o_phase;
    assign o_parity_known = r_o_parity;
    assign o_half_cycle   = r_o_half;
    assign o_obs_count    = r_o_obs;

    `RRSA_ASSERT(a_idle_chain_empty, (r_state == S_IDLE) |-> !tail.tok,
        "search probe still in the chain while idle")
    `RRSA_ASSERT(a_count_bound, r_count <= SLOTS_C,
        "observation count above the table size")
    `RRSA_ASSERT(a_write_in_resolve, wr_en |-> (r_state == S_RESOLVE),
        "table written outside the resolve step")
    `RRSA_ASSERT(a_result_from_resolve, $rose(r_out_valid) |-> $past(r_state == S_RESOLVE),
        "result beat raised without a resolved record")

endmodule

// ----- sv/rrsa_cell.sv -----
// One slot of the assigner table: stored entry, used flag and one search stage.
// Depends on rrsa_pkg.
module rrsa_cell import rrsa_pkg::*; #(
    parameter int unsigned IDX_W   = 6,
    parameter int unsigned CELL_ID = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_entry           i_query,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_probe           i_probe,
    input  logic [IDX_W-1:0] i_idx,
    output t_probe           o_probe,
    output logic [IDX_W-1:0] o_idx
);

    localparam logic [IDX_W-1:0] ID = IDX_W'(CELL_ID);

    logic             r_used;
    t_entry           r_entry;
    t_probe           r_probe;
    logic [IDX_W-1:0] r_idx;
    logic             hit;

    // Only the first used, matching slot along the chain claims the probe.
    assign hit = i_probe.tok && !i_probe.found && r_used && (r_entry == i_query);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_wr_en && i_wr_addr == ID) begin
            r_used <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_addr == ID) begin
            r_entry <= i_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe.tok   <= i_probe.tok;
            r_probe.found <= i_probe.found | hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= hit ? ID : i_idx;
    end

    assign o_probe = r_probe;
    assign o_idx   = r_idx;

endmodule

// ----- sv/rrsa_chain.sv -----
// Row of slot cells; the search probe walks one cell per cycle.
// Depends on rrsa_pkg and rrsa_cell.
module rrsa_chain import rrsa_pkg::*; #(
    parameter int unsigned SLOTS = 64,
    parameter int unsigned IDX_W = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_entry           i_query,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic             i_start,
    output t_probe           o_tail,
    output logic [IDX_W-1:0] o_tail_idx
);

    t_probe           probe [0:SLOTS];
    logic [IDX_W-1:0] idx   [0:SLOTS];

    assign probe[0] = '{tok: i_start, found: 1'b0};
    assign idx[0]   = '0;

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        rrsa_cell #(
            .IDX_W  (IDX_W),
            .CELL_ID(g)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_query  (i_query),
            .i_wr_en  (i_wr_en),
            .i_wr_addr(i_wr_addr),
            .i_probe  (probe[g]),
            .i_idx    (idx[g]),
            .o_probe  (probe[g+1]),
            .o_idx    (idx[g+1])
        );
    end

    assign o_tail     = probe[SLOTS];
    assign o_tail_idx = idx[SLOTS];

endmodule

// ----- dv/range_record_slot_assigner_core_checker.sv -----
`timescale 1ns / 1ps
// Checker for the range record slot assigner: watches both channels and the config port.
// Predicts each record's result from its own slot table and compares every result beat.
// Depends on rrsa_pkg.
module range_record_slot_assigner_core_checker import rrsa_pkg::*; #(
    parameter int unsigned SLOTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_epoch_start,
    input  logic [31:0]          i_track_status,
    input  logic [SAT_W-1:0]     i_sat_number,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic                 i_accepted,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic                 i_band,
    input  logic                 i_system_code,
    input  logic                 i_code_valid,
    input  logic                 i_phase_valid,
    input  logic                 i_parity_known,
    input  logic                 i_half_cycle,
    input  logic [OBS_W-1:0]     i_obs_count,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic              accepted;
        logic [SLOT_W-1:0] slot;
        logic              band;
        logic              bds;
        logic              code_lock;
        logic              phase_lock;
        logic              parity;
        logic              half;
        logic [OBS_W-1:0]  obs;
    } t_placement;

    logic [SAT_W-1:0] table_sat [SLOTS];
    logic             table_bds [SLOTS];
    logic             table_used[SLOTS];
    int unsigned      obs_total;
    logic [CFG_W-1:0] gps_limit;
    logic [CFG_W-1:0] bds_limit;

    t_placement expected_placements[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Decodes one record, updates the slot table and returns the result it must give.
    function automatic t_placement place_record(input logic epoch, input logic [31:0] word,
                                                input logic [SAT_W-1:0] sat);
        t_placement   r;
        logic [2:0]   sys;
        logic [4:0]   sig;
        logic         bds;
        logic         known;
        logic         second;
        int unsigned  pick;
        logic [CFG_W-1:0] limit;
        r   = '0;
        sys = word[SYS_LSB +: 3];
        sig = word[SIG_LSB +: 5];
        if (epoch) begin
            obs_total = 0;
        end
        if (sys == SYS_GPS || sys == SYS_BDS) begin
            bds = (sys == SYS_BDS);
            if (!bds) begin
                second = (sig == SIG_GPS_F2);
                known  = second || (sig == SIG_GPS_F1);
            end else begin
                second = (sig == SIG_BDS_F2A) || (sig == SIG_BDS_F2B);
                known  = second || (sig == SIG_BDS_F1A) || (sig == SIG_BDS_F1B);
            end
            if (known) begin
                pick = obs_total;
                if (second) begin
                    // Walk downward so the lowest matching slot wins.
                    for (int j = SLOTS - 1; j >= 0; j--) begin
                        if (table_used[j] && table_sat[j] == sat && table_bds[j] == bds) begin
                            pick = j;
                        end
                    end
                end
                if (pick < SLOTS) begin
                    table_sat[pick]  = sat;
                    table_bds[pick]  = bds;
                    table_used[pick] = 1'b1;
                    limit = bds ? bds_limit : gps_limit;
                    if (sat <= limit) begin
                        if (!second && obs_total < SLOTS) begin
                            obs_total++;
                        end
                        r.accepted   = 1'b1;
                        r.slot       = pick[SLOT_W-1:0];
                        r.band       = second;
                        r.bds        = bds;
                        r.code_lock  = word[CODE_BIT];
                        r.phase_lock = word[PHASE_BIT];
                        r.parity     = word[PARITY_BIT];
                        r.half       = word[HALF_BIT];
                    end
                end
            end
        end
        r.obs = obs_total[OBS_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_placement want;
        if (!i_rst_n) begin
            for (int j = 0; j < SLOTS; j++) begin
                table_sat[j]  = '0;
                table_bds[j]  = 1'b0;
                table_used[j] = 1'b0;
            end
            obs_total = 0;
            gps_limit = MAX_GPS_RESET;
            bds_limit = MAX_BDS_RESET;
            expected_placements.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_MAX_GPS) begin
                    gps_limit = i_cfg_data;
                end else if (i_cfg_index == REG_MAX_BDS) begin
                    bds_limit = i_cfg_data;
                end
            end
            // The result leaving now is always older than a record entering now.
            if (i_out_valid && !i_out_stall) begin
                if (expected_placements.size() == 0) begin
                    $error("result beat with no record waiting for it");
                    o_fail_count++;
                end else begin
                    want = expected_placements.pop_front();
                    check_field("accepted", want.accepted, i_accepted);
                    check_field("slot", want.slot, i_slot);
                    check_field("band", want.band, i_band);
                    check_field("system_code", want.bds, i_system_code);
                    check_field("code_valid", want.code_lock, i_code_valid);
                    check_field("phase_valid", want.phase_lock, i_phase_valid);
                    check_field("parity_known", want.parity, i_parity_known);
                    check_field("half_cycle", want.half, i_half_cycle);
                    check_field("obs_count", want.obs, i_obs_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_placements.push_back(
                    place_record(i_epoch_start, i_track_status, i_sat_number));
            end
        end
        o_pending = expected_placements.size();
    end

endmodule

// ----- dv/range_record_slot_assigner_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the range record slot assigner: clock, reset, record stimulus and verdict.
// Depends on rrsa_pkg, range_record_slot_assigner_core and its checker module.
module range_record_slot_assigner_core_tb;
    import rrsa_pkg::*;

    localparam int unsigned SLOTS = 64;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = REG_MAX_GPS;
    logic [CFG_W-1:0]     i_cfg_data     = '0;
    logic                 i_in_valid     = 1'b0;
    logic                 i_epoch_start  = 1'b0;
    logic [31:0]          i_track_status = '0;
    logic [SAT_W-1:0]     i_sat_number   = '0;
    logic                 i_out_stall    = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_accepted;
    logic [SLOT_W-1:0]    o_slot;
    logic                 o_band;
    logic                 o_system_code;
    logic                 o_code_valid;
    logic                 o_phase_valid;
    logic                 o_parity_known;
    logic                 o_half_cycle;
    logic [OBS_W-1:0]     o_obs_count;
    int                   fail_count;
    int                   pending;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          records_sent   = 0;
    logic [7:0]  gps_lim        = MAX_GPS_RESET;
    logic [7:0]  bds_lim        = MAX_BDS_RESET;

    range_record_slot_assigner_core #(.SLOTS(SLOTS)) u_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_stall, .i_epoch_start, .i_track_status, .i_sat_number,
        .o_out_valid, .i_out_stall, .o_accepted, .o_slot, .o_band, .o_system_code,
        .o_code_valid, .o_phase_valid, .o_parity_known, .o_half_cycle, .o_obs_count
    );

    range_record_slot_assigner_core_checker #(.SLOTS(SLOTS)) u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_epoch_start, .i_track_status,
        .i_sat_number, .i_out_valid(o_out_valid), .i_out_stall,
        .i_accepted(o_accepted), .i_slot(o_slot), .i_band(o_band),
        .i_system_code(o_system_code), .i_code_valid(o_code_valid),
        .i_phase_valid(o_phase_valid), .i_parity_known(o_parity_known),
        .i_half_cycle(o_half_cycle), .i_obs_count(o_obs_count),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Random tracking word with the system and signal fields forced.
    function automatic logic [31:0] track_word(input logic [2:0] sys, input logic [4:0] sig);
        logic [31:0] w;
        w = $urandom;
        w[SYS_LSB +: 3] = sys;
        w[SIG_LSB +: 5] = sig;
        return w;
    endfunction

    function automatic logic [31:0] first_band_word(input logic bds);
        if (!bds) begin
            return track_word(SYS_GPS, SIG_GPS_F1);
        end
        return track_word(SYS_BDS, $urandom_range(1) ? SIG_BDS_F1A : SIG_BDS_F1B);
    endfunction

    function automatic logic [31:0] second_band_word(input logic bds);
        if (!bds) begin
            return track_word(SYS_GPS, SIG_GPS_F2);
        end
        return track_word(SYS_BDS, $urandom_range(1) ? SIG_BDS_F2A : SIG_BDS_F2B);
    endfunction

    function automatic logic [SAT_W-1:0] pick_sat(input logic bds);
        int unsigned lim;
        int unsigned r;
        lim = bds ? bds_lim : gps_lim;
        r   = $urandom_range(99);
        if (r < 80) begin
            return $urandom_range(lim, 1);
        end else if (r < 88) begin
            return lim + 1 + $urandom_range(200);
        end else if (r < 93) begin
            return '0;
        end
        return $urandom;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_record(input logic epoch, input logic [31:0] word,
                               input logic [SAT_W-1:0] sat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_epoch_start  <= epoch;
        i_track_status <= word;
        i_sat_number   <= sat;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        records_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SLOTS + 8) @(negedge i_clk);
    endtask

    task automatic write_limits(input logic [7:0] gps, input logic [7:0] bds);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_MAX_GPS;
        i_cfg_data  <= gps;
        @(negedge i_clk);
        i_cfg_index <= REG_MAX_BDS;
        i_cfg_data  <= bds;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gps_lim = gps;
        bds_lim = bds;
    endtask

    task automatic send_noise();
        logic [2:0] sys;
        logic [31:0] word;
        logic [SAT_W-1:0] sat;
        case ($urandom_range(2))
            0: word = $urandom;
            1: word = track_word($urandom_range(1) ? SYS_BDS : SYS_GPS, $urandom);
            default: begin
                sys = $urandom;
                while (sys == SYS_GPS || sys == SYS_BDS) begin
                    sys = $urandom;
                end
                word = track_word(sys, $urandom);
            end
        endcase
        sat = $urandom_range(1) ? $urandom : $urandom_range(300);
        send_record($urandom_range(9) == 0, word, sat);
    endtask

    // One epoch: first-band records fill slots, then second-band records look them up.
    task automatic send_epoch();
        int unsigned      n_first;
        logic             bds;
        logic [SAT_W-1:0] sat;
        logic [SAT_W-1:0] sats[$];
        logic             systems[$];
        n_first = ($urandom_range(7) == 0) ? $urandom_range(70, 60) : $urandom_range(12, 1);
        for (int i = 0; i < n_first; i++) begin
            bds = $urandom_range(1);
            sat = pick_sat(bds);
            send_record(i == 0, first_band_word(bds), sat);
            sats.push_back(sat);
            systems.push_back(bds);
        end
        for (int i = 0; i < n_first; i++) begin
            if ($urandom_range(9) < 7) begin
                send_record(1'b0, second_band_word(systems[i]), sats[i]);
            end
            if ($urandom_range(19) == 0) begin
                bds = $urandom_range(1);
                send_record(1'b0, second_band_word(bds), pick_sat(bds));
            end
            if ($urandom_range(29) == 0) begin
                send_noise();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_limits(MAX_GPS_RESET, MAX_BDS_RESET);

        // Directed records at the reset limits.
        send_record(1'b1, track_word(SYS_GPS, SIG_GPS_F1), 16'd1);
        send_record(1'b0, track_word(SYS_GPS, SIG_GPS_F1), 16'd32);
        // Out of range: written to the slot but not counted.
        send_record(1'b0, track_word(SYS_GPS, SIG_GPS_F1), 16'd33);
        send_record(1'b0, track_word(SYS_GPS, SIG_GPS_F2), 16'd1);
        send_record(1'b0, track_word(SYS_GPS, SIG_GPS_F2), 16'd33);
        send_record(1'b0, track_word(SYS_BDS, SIG_BDS_F1A), 16'd63);
        send_record(1'b0, track_word(SYS_BDS, SIG_BDS_F1B), 16'd0);
        send_record(1'b0, track_word(SYS_BDS, SIG_BDS_F2A), 16'd63);
        send_record(1'b0, track_word(SYS_BDS, SIG_BDS_F2B), 16'd64);
        send_record(1'b0, track_word(SYS_BDS, SIG_BDS_F2B), 16'd0);
        send_record(1'b0, track_word(3'd1, SIG_GPS_F1), 16'd5);
        send_record(1'b0, track_word(3'd7, SIG_GPS_F1), 16'd5);
        send_record(1'b0, track_word(SYS_GPS, 5'd4), 16'd5);
        send_record(1'b0, track_word(SYS_BDS, 5'd9), 16'd5);
        send_record(1'b0, track_word(SYS_GPS, SIG_GPS_F1), 16'hFFFF);
        send_record(1'b0, 32'hFFFF_FFFF & ~(32'h7 << SYS_LSB) & ~(32'h1F << SIG_LSB), 16'd7);
        send_record(1'b0, 32'h0, 16'd8);
        send_record(1'b1, track_word(SYS_GPS, SIG_GPS_F2), 16'd32);
        send_record(1'b0, 32'hFFFF_FFFF, 16'hFFFF);

        for (int seg = 0; seg < 6; seg++) begin
            wait_idle();
            case (seg)
                0: write_limits(8'd255, 8'd1);
                1: write_limits(8'd1, 8'd255);
                2: write_limits(8'd255, 8'd255);
                3: write_limits(8'd1, 8'd1);
                default: write_limits($urandom_range(255, 1), $urandom_range(255, 1));
            endcase
            case (seg / 2)
                0: begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 87;
                end
                1: begin
                    send_idle_pct  = 87;
                    recv_stall_pct = 13;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            while (records_sent < 25 + 300 * (seg + 1)) begin
                if ($urandom_range(4) == 0) begin
                    send_noise();
                end else begin
                    send_epoch();
                end
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
